// ===== src/ltc_pkg.sv =====
// Package for the lexical token classifier: payload structs, token codes,
// recognizer states and the keyword, operator and delimiter tables.
// No dependencies.
package ltc_pkg;

	// Longest prefix that is compared against the tables
	localparam int MATCH_LENGTH = 8;
	localparam int POS_W        = $clog2(MATCH_LENGTH + 1);

	localparam int NUM_KEYS   = 26;
	localparam int NUM_OPS    = 27;
	localparam int NUM_DELS   = 8;
	localparam int WORD_BYTES = 8;
	localparam int LEN_W      = 4;
	localparam int COL_W      = 3;
	localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
	localparam int OP_IDX_W   = $clog2(NUM_OPS);
	localparam int DEL_IDX_W  = $clog2(NUM_DELS);

	// Category codes
	localparam logic [2:0] CAT_KEYWORD    = 3'd0;
	localparam logic [2:0] CAT_OPERATOR   = 3'd1;
	localparam logic [2:0] CAT_DELIMITER  = 3'd2;
	localparam logic [2:0] CAT_IDENTIFIER = 3'd3;
	localparam logic [2:0] CAT_INTEGER    = 3'd4;
	localparam logic [2:0] CAT_FLOAT      = 3'd5;
	localparam logic [2:0] CAT_STRING     = 3'd6;
	localparam logic [2:0] CAT_INVALID    = 3'd7;

	// Token codes
	localparam logic [8:0] KEY_BASE     = 9'd1;
	localparam logic [8:0] OP_BASE      = 9'd50;
	localparam logic [8:0] DEL_BASE     = 9'd100;
	localparam logic [8:0] CODE_IDENT   = 9'd150;
	localparam logic [8:0] CODE_INT     = 9'd151;
	localparam logic [8:0] CODE_ZERO    = 9'd152;
	localparam logic [8:0] CODE_FLOAT   = 9'd153;
	localparam logic [8:0] CODE_STRING  = 9'd154;
	localparam logic [8:0] CODE_INVALID = 9'd404;

	typedef enum logic [3:0] {
		ST_START     = 4'd1,
		ST_IDENT     = 4'd2,
		ST_SIGN      = 4'd3,
		ST_INT       = 4'd4,
		ST_ZERO      = 4'd5,
		ST_STR       = 4'd6,
		ST_POINT     = 4'd7,
		ST_FRAC      = 4'd8,
		ST_STR_DONE  = 4'd9,
		ST_INVALID   = 4'd10,
		ST_SIGN_ZERO = 4'd11
	} rec_state_t;

	typedef struct packed {
		logic [7:0]  character;
		logic        last;
		logic [15:0] line_number;
	} ltc_in_t;

	typedef struct packed {
		logic [2:0]  category;
		logic [8:0]  token_code;
		logic [15:0] line_out;
	} ltc_out_t;

	typedef struct packed {
		logic                 kw_hit;
		logic [KEY_IDX_W-1:0] kw_idx;
		logic                 op_hit;
		logic [OP_IDX_W-1:0]  op_idx;
		logic                 del_hit;
		logic [DEL_IDX_W-1:0] del_idx;
	} ltc_match_t;

	// Text is right-justified: first character sits in byte len-1
	typedef logic [WORD_BYTES-1:0][7:0] word_text_t;

	localparam word_text_t KEY_TEXT [NUM_KEYS] = '{
		"auto", "boolean", "break", "case", "char", "continue", "default",
		"do", "double", "else", "false", "float", "for", "goto", "if",
		"int", "long", "main", "printf", "return", "scanf", "string",
		"switch", "true", "void", "while"
	};
	localparam logic [LEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
		4'd4, 4'd7, 4'd5, 4'd4, 4'd4, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd5,
		4'd5, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd5, 4'd6,
		4'd6, 4'd4, 4'd4, 4'd5
	};

	localparam word_text_t OP_TEXT [NUM_OPS] = '{
		"!", "!=", "%", "&", "&&", "&=", "*", "*=", "+", "+=", "-", "-=",
		"/", "/=", ":", ":=", "<", "<=", "=", "==", ">", ">=", "?", "^",
		"|", "|=", "||"
	};
	localparam logic [LEN_W-1:0] OP_LEN [NUM_OPS] = '{
		4'd1, 4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1,
		4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2,
		4'd1, 4'd1, 4'd1, 4'd2, 4'd2
	};

	localparam word_text_t DEL_TEXT [NUM_DELS] = '{
		"(", ")", ",", ";", "[", "]", "{", "}"
	};
	localparam logic [LEN_W-1:0] DEL_LEN [NUM_DELS] = '{
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
	};

	// Candidate survives this character
	function automatic logic word_keep(word_text_t text, logic [LEN_W-1:0] len,
			logic [POS_W-1:0] pos, logic [7:0] c);
		logic [POS_W:0] pos_x;
		logic [POS_W:0] len_x;
		logic [COL_W-1:0] col;
		pos_x = {1'b0, pos};
		len_x = (POS_W + 1)'(len);
		col   = COL_W'(len_x - pos_x - 1'b1);
		return (pos_x < (POS_W + 1)'(MATCH_LENGTH)) && (pos_x < len_x) &&
			(text[col] == c);
	endfunction

	// Word ends exactly at this character
	function automatic logic word_full(logic [LEN_W-1:0] len, logic [POS_W-1:0] pos);
		return (POS_W + 1)'(len) == ({1'b0, pos} + 1'b1);
	endfunction

endpackage

// ===== src/ltc_match.sv =====
// Candidate mask narrowing and exact-match priority pick for the three tables.
// Depends on ltc_pkg.
module ltc_match (
	input  logic [ltc_pkg::POS_W-1:0]    pos,
	input  logic [7:0]                   character,
	input  logic [ltc_pkg::NUM_KEYS-1:0] kw_mask,
	input  logic [ltc_pkg::NUM_OPS-1:0]  op_mask,
	input  logic [ltc_pkg::NUM_DELS-1:0] del_mask,
	output logic [ltc_pkg::NUM_KEYS-1:0] kw_next,
	output logic [ltc_pkg::NUM_OPS-1:0]  op_next,
	output logic [ltc_pkg::NUM_DELS-1:0] del_next,
	output ltc_pkg::ltc_match_t          match
);
	import ltc_pkg::*;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			kw_next[k] = kw_mask[k] & word_keep(KEY_TEXT[k], KEY_LEN[k], pos, character);
		end
		for (int k = 0; k < NUM_OPS; k++) begin
			op_next[k] = op_mask[k] & word_keep(OP_TEXT[k], OP_LEN[k], pos, character);
		end
		for (int k = 0; k < NUM_DELS; k++) begin
			del_next[k] = del_mask[k] & word_keep(DEL_TEXT[k], DEL_LEN[k], pos, character);
		end
	end

	// Lowest index wins: scan downward so the last hit written is the lowest
	always_comb begin
		match = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (kw_next[k] && word_full(KEY_LEN[k], pos)) begin
				match.kw_hit = 1'b1;
				match.kw_idx = KEY_IDX_W'(k);
			end
		end
		for (int k = NUM_OPS - 1; k >= 0; k--) begin
			if (op_next[k] && word_full(OP_LEN[k], pos)) begin
				match.op_hit = 1'b1;
				match.op_idx = OP_IDX_W'(k);
			end
		end
		for (int k = NUM_DELS - 1; k >= 0; k--) begin
			if (del_next[k] && word_full(DEL_LEN[k], pos)) begin
				match.del_hit = 1'b1;
				match.del_idx = DEL_IDX_W'(k);
			end
		end
	end

endmodule

// ===== src/lexical_token_classifier_top.sv =====
// Top level of the lexical token classifier: input register, per-token state,
// recognizer FSM and result register. Depends on ltc_pkg and ltc_match.
//
// Usage: send the bytes of one already-split token, one request per byte,
// with last set on the final byte. The block returns one result per token:
// a category, a token code and the line number of the final byte. Exact
// matches against the keyword table (codes 1..26), operator table (50..76)
// and delimiter table (100..107) win in that order; otherwise a small
// recognizer decides identifier (150), nonzero integer (151), zero (152),
// float (153), string (154) or invalid (404). Only the first MATCH_LENGTH
// bytes take part in table matching. Rate: one byte per clock, sustained
// for as long as results are taken; rsp_valid rises once the final byte
// has passed through the input register and its result has been loaded
// into the result register. req_ready drops only when a final byte sits in
// the input register while the result register still holds an untaken
// result. No reset sweep: the block is ready right after reset.
module lexical_token_classifier_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ltc_pkg::ltc_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ltc_pkg::ltc_out_t rsp
);
	import ltc_pkg::*;

	// Input register
	logic    valid_s1;
	ltc_in_t req_s1;

	// Per-token state
	rec_state_t            state_q;
	rec_state_t            state_n;
	logic [NUM_KEYS-1:0]   kw_mask_q;
	logic [NUM_OPS-1:0]    op_mask_q;
	logic [NUM_DELS-1:0]   del_mask_q;
	logic [POS_W-1:0]      pos_q;
	logic [NUM_KEYS-1:0]   kw_next;
	logic [NUM_OPS-1:0]    op_next;
	logic [NUM_DELS-1:0]   del_next;
	ltc_match_t            match;

	// Result register
	logic     rsp_valid_q;
	ltc_out_t rsp_q;

	logic       advance_s1;
	logic       finish_s1;
	logic [2:0] rec_cat;
	logic [8:0] rec_code;
	ltc_out_t   result;

	// A non-final byte only touches state, so it never waits on the output
	assign advance_s1 = valid_s1 && (!req_s1.last || !rsp_valid_q || rsp_ready);
	assign finish_s1  = advance_s1 && req_s1.last;
	assign req_ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	ltc_match u_match (
		.pos       (pos_q),
		.character (req_s1.character),
		.kw_mask   (kw_mask_q),
		.op_mask   (op_mask_q),
		.del_mask  (del_mask_q),
		.kw_next   (kw_next),
		.op_next   (op_next),
		.del_next  (del_next),
		.match     (match)
	);

	// Recognizer next state
	always_comb begin
		logic [7:0] c;
		logic       is_alpha;
		logic       is_digit;
		c        = req_s1.character;
		is_alpha = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
		is_digit = c inside {[8'h30:8'h39]};
		case (state_q)
			ST_START: begin
				if (is_alpha)                     state_n = ST_IDENT;
				else if (c == "+" || c == "-")    state_n = ST_SIGN;
				else if (c == "0")                state_n = ST_ZERO;
				else if (is_digit)                state_n = ST_INT;
				else if (c == 8'h22)              state_n = ST_STR;
				else                              state_n = ST_INVALID;
			end
			ST_IDENT: begin
				state_n = (is_alpha || is_digit || c == "_") ? ST_IDENT : ST_INVALID;
			end
			ST_SIGN: begin
				if (c == "0")      state_n = ST_SIGN_ZERO;
				else if (is_digit) state_n = ST_INT;
				else               state_n = ST_INVALID;
			end
			ST_INT: begin
				if (is_digit)      state_n = ST_INT;
				else if (c == ".") state_n = ST_POINT;
				else               state_n = ST_INVALID;
			end
			ST_ZERO, ST_SIGN_ZERO: begin
				state_n = (c == ".") ? ST_POINT : ST_INVALID;
			end
			ST_STR: begin
				state_n = (c == 8'h22) ? ST_STR_DONE : ST_STR;
			end
			ST_POINT, ST_FRAC: begin
				state_n = is_digit ? ST_FRAC : ST_INVALID;
			end
			ST_STR_DONE: begin
				state_n = ST_STR_DONE;
			end
			default: begin
				state_n = ST_INVALID;
			end
		endcase
	end

	// Recognizer outputs, decoded from the state after this byte
	always_comb begin
		case (state_n)
			ST_IDENT: begin
				rec_cat  = CAT_IDENTIFIER;
				rec_code = CODE_IDENT;
			end
			ST_INT: begin
				rec_cat  = CAT_INTEGER;
				rec_code = CODE_INT;
			end
			ST_ZERO: begin
				rec_cat  = CAT_INTEGER;
				rec_code = CODE_ZERO;
			end
			ST_FRAC: begin
				rec_cat  = CAT_FLOAT;
				rec_code = CODE_FLOAT;
			end
			ST_STR_DONE: begin
				rec_cat  = CAT_STRING;
				rec_code = CODE_STRING;
			end
			default: begin
				rec_cat  = CAT_INVALID;
				rec_code = CODE_INVALID;
			end
		endcase
	end

	// Table matches take priority over the recognizer
	always_comb begin
		result.line_out = req_s1.line_number;
		if (match.kw_hit) begin
			result.category   = CAT_KEYWORD;
			result.token_code = KEY_BASE + 9'(match.kw_idx);
		end else if (match.op_hit) begin
			result.category   = CAT_OPERATOR;
			result.token_code = OP_BASE + 9'(match.op_idx);
		end else if (match.del_hit) begin
			result.category   = CAT_DELIMITER;
			result.token_code = DEL_BASE + 9'(match.del_idx);
		end else begin
			result.category   = rec_cat;
			result.token_code = rec_code;
		end
	end

	// Token state: back to start after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_START;
			kw_mask_q  <= '1;
			op_mask_q  <= '1;
			del_mask_q <= '1;
			pos_q      <= '0;
		end else if (advance_s1) begin
			if (req_s1.last) begin
				state_q    <= ST_START;
				kw_mask_q  <= '1;
				op_mask_q  <= '1;
				del_mask_q <= '1;
				pos_q      <= '0;
			end else begin
				state_q    <= state_n;
				kw_mask_q  <= kw_next;
				op_mask_q  <= op_next;
				del_mask_q <= del_next;
				if (pos_q < POS_W'(MATCH_LENGTH)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_s1) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MATCH_LENGTH))
		else $error("position count above match length");

	a_token_restart: assert property (@(posedge clk) disable iff (!arst_n)
		finish_s1 |=> (state_q == ST_START && pos_q == '0 && (&kw_mask_q)))
		else $error("token state not restarted after final byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && req_s1.last && rsp_valid_q && !rsp_ready))
		else $error("input stalled without a blocked result");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		finish_s1 |=> (rsp_valid && rsp == $past(result)))
		else $error("result register not loaded");

	a_keyword_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.category == CAT_KEYWORD) |->
			(rsp.token_code >= KEY_BASE && rsp.token_code < KEY_BASE + 9'(NUM_KEYS)))
		else $error("keyword code out of range");
`endif

endmodule
